// ===== rtl/set_assoc_cache_tag_store_core_macros.svh =====
// ----------------------------------------------------------------------------
// Set-associative cache tag store: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TAG_STORE_CORE_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_STORE_CORE_MACROS_SVH

// Implication checked in the same cycle.
`define SAC_TS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle.
`define SAC_TS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sac_ts_pkg.sv =====
// ----------------------------------------------------------------------------
// Set-associative cache tag store: package
// Shared constants, state encoding and interface types of the tag store.
// ----------------------------------------------------------------------------
package sac_ts_pkg;

  // Default sizes of the store.
  localparam int unsigned DefMaxWayCount = 16;
  localparam int unsigned DefMaxSetBits  = 10;

  // Field widths.
  localparam int unsigned AddrW   = 32;
  localparam int unsigned StampW  = 32;
  localparam int unsigned CountW  = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 5;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 200;

  // Modulo unit widths: the dividend is the LFSR, the divisor at most 32.
  localparam int unsigned LfsrW   = 16;
  localparam int unsigned DivisorW = 6;
  localparam logic [LfsrW-1:0] LfsrSeed = 16'hACE1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgRandomRepl = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWaysInUse  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSetBits    = 2'd2;

  // Request kinds.
  localparam logic ReqLookup  = 1'b0;
  localparam logic ReqInstall = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_LRU,
    S_MOD,
    S_WRITE
  } state_e;

  // Request to the modulo unit.
  typedef struct packed {
    logic                start;
    logic [LfsrW-1:0]    dividend;
    logic [DivisorW-1:0] divisor;
  } mod_req_t;

  // Response from the modulo unit.
  typedef struct packed {
    logic                done;
    logic [DivisorW-1:0] rem;
  } mod_rsp_t;

endpackage

// ===== rtl/sac_ts_mod.sv =====
// ----------------------------------------------------------------------------
// Set-associative cache tag store: modulo unit
// Restoring remainder of a 16-bit value by a small divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module sac_ts_mod (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sac_ts_pkg::mod_req_t  req_i,
  output sac_ts_pkg::mod_rsp_t  rsp_o
);
  import sac_ts_pkg::*;

  localparam int unsigned CntW = $clog2(LfsrW);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [LfsrW-1:0]    div_q, div_d;
  logic [DivisorW-1:0] dsr_q, dsr_d;
  logic [DivisorW-1:0] rem_q, rem_d;
  logic [DivisorW-1:0] trial;

  // Shift in the next dividend bit and subtract when it fits.
  assign trial = {rem_q[DivisorW-2:0], div_q[LfsrW-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      div_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = (trial >= dsr_q) ? trial - dsr_q : trial;
      div_d = {div_q[LfsrW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(LfsrW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand registers carry no reset.
  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== rtl/set_assoc_cache_tag_store_core.sv =====
// ----------------------------------------------------------------------------
// Set-associative cache tag store
// One row per set holds valid, dirty, tag and stamp of all ways; each item
// reads its row, and a hit or an install updates it and writes it back.
// ----------------------------------------------------------------------------
// Usage: items enter on the s_axis channel (lookup or install) and every item
// gives exactly one result item on the m_axis channel, carrying hit, victim
// and the running statistics. Configuration writes go through the always ready
// cfg channel; the user makes them while no item is in flight (not enforced).
// A lookup is resolved in the evaluation state; an install that finds a free
// way goes on to the write state, a least recently used eviction first scans
// the ways in use (one stamp compared per cycle), and a random eviction first
// forms the LFSR modulo the way count one bit per cycle.
// One item is worked on at a time; the next is taken only after the previous
// one has loaded its result into the output register.
// After reset the set memory is cleared one row per cycle, all 2**MAX_SET_BITS
// rows, with s_axis_tready low.
// A finished result waits in the output register; a stalled receiver holds
// the next item in its last stage until the output register is free.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_tag_store_core_macros.svh"

module set_assoc_cache_tag_store_core #(
  parameter int unsigned MAX_WAY_COUNT = sac_ts_pkg::DefMaxWayCount,
  parameter int unsigned MAX_SET_BITS  = sac_ts_pkg::DefMaxSetBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input items.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: line_addr [31:0], timestamp [63:32]
  input  logic [sac_ts_pkg::InDataW-1:0]    s_axis_tdata,
  // tuser: req_type [0], write_flag [1]
  input  logic [sac_ts_pkg::InUserW-1:0]    s_axis_tuser,
  // Result items.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: hit [0], victim_valid [1], victim_dirty [2], victim_line_addr [34:3],
  // read_accesses [66:35], write_accesses [98:67], read_misses [130:99],
  // write_misses [162:131], dirty_evictions [194:163], zero fill [199:195]
  output logic [sac_ts_pkg::OutDataW-1:0]   m_axis_tdata,
  // Configuration writes.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sac_ts_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [sac_ts_pkg::CfgDatW-1:0]    cfg_data_i
);
  import sac_ts_pkg::*;

  localparam int unsigned Ways   = MAX_WAY_COUNT;
  localparam int unsigned Sets   = 2 ** MAX_SET_BITS;
  localparam int unsigned SetW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned WayW   = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned CntW   = $clog2(Ways + 1);

  typedef struct packed {
    logic [Ways-1:0]             valid;
    logic [Ways-1:0]             dirty;
    logic [Ways-1:0][AddrW-1:0]  tag;
    logic [Ways-1:0][StampW-1:0] stamp;
  } row_t;

  // Configuration registers.
  logic       rand_q;
  logic [4:0] ways_cfg_q;
  logic [3:0] sbits_cfg_q;

  // Control state.
  state_e          state_q, state_d;
  logic [SetW-1:0] clr_idx_q;
  logic [LfsrW-1:0] lfsr_q;
  logic [LfsrW-1:0] lfsr_nxt;

  // Item registers.
  logic              req_q;
  logic              dirty_q;
  logic [AddrW-1:0]  addr_q;
  logic [StampW-1:0] stamp_q;
  logic [SetW-1:0]   set_q;

  // Victim choice.
  logic [WayW-1:0]   slot_q;
  logic [WayW-1:0]   w_q;
  logic [StampW-1:0] best_q;
  logic              vvalid_q;

  // Statistics.
  logic [CountW-1:0] rd_acc_q, wr_acc_q, rd_miss_q, wr_miss_q, dev_q;
  logic [CountW-1:0] rd_acc_d, wr_acc_d, rd_miss_d, wr_miss_d, dev_d;

  // Output register.
  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;

  // Set memory.
  row_t            line_mem [Sets];
  row_t            rdata_q;
  logic            mem_we;
  logic [SetW-1:0] mem_waddr;
  row_t            mem_wdata;

  // Effective configuration.
  logic [CntW-1:0] ways_eff;
  logic [3:0]      sbits_eff;
  logic [SetW-1:0] in_set;

  // Search results.
  logic            hit;
  logic [WayW-1:0] hit_way;
  logic            has_inv;
  logic [WayW-1:0] inv_way;
  logic            lru_last;
  logic            clr_last;

  logic            in_acc;
  logic            out_busy;
  logic            out_load;
  logic [OutDataW-1:0] out_data;

  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  // Clamp the configured way count and index width.
  always_comb begin
    if (ways_cfg_q == 5'd0) begin
      ways_eff = CntW'(1);
    end else if ({1'b0, ways_cfg_q} > 6'(Ways)) begin
      ways_eff = CntW'(Ways);
    end else begin
      ways_eff = CntW'(ways_cfg_q);
    end
    sbits_eff = ({1'b0, sbits_cfg_q} > 5'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : sbits_cfg_q;
  end

  // Set index from the low line address bits that are in use.
  always_comb begin
    for (int i = 0; i < SetW; i++) begin
      in_set[i] = (MAX_SET_BITS > 0) && (5'(i) < {1'b0, sbits_eff}) && s_axis_tdata[i];
    end
  end

  // Tag match and first free way among the ways in use.
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    has_inv = 1'b0;
    inv_way = '0;
    for (int w = Ways - 1; w >= 0; w--) begin
      if (CntW'(w) < ways_eff) begin
        if (rdata_q.valid[w] && (rdata_q.tag[w] == addr_q)) begin
          hit     = 1'b1;
          hit_way = WayW'(w);
        end
        if (!rdata_q.valid[w]) begin
          has_inv = 1'b1;
          inv_way = WayW'(w);
        end
      end
    end
  end

  assign lfsr_nxt = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[LfsrW-1:1]};
  assign lru_last = ({1'b0, CntW'(w_q)} == ({1'b0, ways_eff} - 1'b1));
  assign clr_last = (clr_idx_q == SetW'(Sets - 1));
  assign out_busy = m_valid_q && !m_axis_tready;
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_last) state_d = S_IDLE;
      S_IDLE:  if (in_acc) state_d = S_EVAL;
      S_EVAL: begin
        if (req_q == ReqLookup) begin
          if (!out_busy) state_d = S_IDLE;
        end else if (has_inv) begin
          state_d = S_WRITE;
        end else if (rand_q) begin
          state_d = S_MOD;
        end else if (ways_eff == CntW'(1)) begin
          state_d = S_WRITE;
        end else begin
          state_d = S_LRU;
        end
      end
      S_LRU:   if (lru_last) state_d = S_WRITE;
      S_MOD:   if (mod_rsp.done) state_d = S_WRITE;
      S_WRITE: if (!out_busy) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  // Sequencer outputs: ready, memory write, modulo start, statistics, result.
  always_comb begin
    s_axis_tready  = (state_q == S_IDLE);
    mem_we         = 1'b0;
    mem_waddr      = set_q;
    mem_wdata      = rdata_q;
    out_load       = 1'b0;
    out_data       = '0;
    mod_req.start    = 1'b0;
    mod_req.dividend = lfsr_nxt;
    mod_req.divisor  = DivisorW'(ways_eff);
    rd_acc_d  = rd_acc_q;
    wr_acc_d  = wr_acc_q;
    rd_miss_d = rd_miss_q;
    wr_miss_d = wr_miss_q;
    dev_d     = dev_q;
    unique case (state_q)
      S_CLEAR: begin
        mem_we          = 1'b1;
        mem_waddr       = clr_idx_q;
        mem_wdata       = '0;
      end
      S_EVAL: begin
        if (req_q == ReqLookup) begin
          if (!out_busy) begin
            if (dirty_q) wr_acc_d = wr_acc_q + 1'b1;
            else         rd_acc_d = rd_acc_q + 1'b1;
            if (!hit && dirty_q)  wr_miss_d = wr_miss_q + 1'b1;
            if (!hit && !dirty_q) rd_miss_d = rd_miss_q + 1'b1;
            mem_we = hit;
            mem_wdata.stamp[hit_way] = stamp_q;
            if (dirty_q) mem_wdata.dirty[hit_way] = 1'b1;
            out_load = 1'b1;
            out_data = {5'd0, dev_d, wr_miss_d, rd_miss_d, wr_acc_d, rd_acc_d,
                        {AddrW{1'b0}}, 1'b0, 1'b0, hit};
          end
        end else begin
          mod_req.start = !has_inv && rand_q;
        end
      end
      S_WRITE: begin
        if (!out_busy) begin
          if (vvalid_q && rdata_q.dirty[slot_q]) dev_d = dev_q + 1'b1;
          mem_we = 1'b1;
          mem_wdata.valid[slot_q] = 1'b1;
          mem_wdata.dirty[slot_q] = dirty_q;
          mem_wdata.tag[slot_q]   = addr_q;
          mem_wdata.stamp[slot_q] = stamp_q;
          out_load = 1'b1;
          out_data = {5'd0, dev_d, wr_miss_d, rd_miss_d, wr_acc_d, rd_acc_d,
                      vvalid_q ? rdata_q.tag[slot_q] : {AddrW{1'b0}},
                      vvalid_q && rdata_q.dirty[slot_q], vvalid_q, 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_idx_q   <= '0;
      lfsr_q      <= LfsrSeed;
      rand_q      <= 1'b0;
      ways_cfg_q  <= 5'd16;
      sbits_cfg_q <= 4'd10;
      rd_acc_q    <= '0;
      wr_acc_q    <= '0;
      rd_miss_q   <= '0;
      wr_miss_q   <= '0;
      dev_q       <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_acc_q  <= rd_acc_d;
      wr_acc_q  <= wr_acc_d;
      rd_miss_q <= rd_miss_d;
      wr_miss_q <= wr_miss_d;
      dev_q     <= dev_d;
      if (state_q == S_CLEAR) clr_idx_q <= clr_idx_q + 1'b1;
      if (mod_req.start) lfsr_q <= lfsr_nxt;
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgRandomRepl) rand_q      <= cfg_data_i[0];
        if (cfg_index_i == CfgWaysInUse)  ways_cfg_q  <= cfg_data_i;
        if (cfg_index_i == CfgSetBits)    sbits_cfg_q <= cfg_data_i[3:0];
      end
      if (out_load)           m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  assign cfg_ready_o = 1'b1;

  // Item and victim search registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q   <= s_axis_tuser[0];
      dirty_q <= s_axis_tuser[1];
      addr_q  <= s_axis_tdata[AddrW-1:0];
      stamp_q <= s_axis_tdata[InDataW-1:AddrW];
      set_q   <= in_set;
    end
    if (state_q == S_EVAL) begin
      slot_q   <= has_inv ? inv_way : '0;
      best_q   <= rdata_q.stamp[0];
      w_q      <= WayW'(1);
      vvalid_q <= !has_inv;
    end
    if (state_q == S_LRU) begin
      if (rdata_q.stamp[w_q] < best_q) begin
        best_q <= rdata_q.stamp[w_q];
        slot_q <= w_q;
      end
      w_q <= w_q + 1'b1;
    end
    if ((state_q == S_MOD) && mod_rsp.done) slot_q <= WayW'(mod_rsp.rem);
    if (out_load) m_data_q <= out_data;
  end

  // Set memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) line_mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) rdata_q <= line_mem[in_set];
  end

  sac_ts_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // No item enters while the memory is being cleared.
  `SAC_TS_ASSERT_NOW(a_no_accept_in_clear, state_q == S_CLEAR, !s_axis_tready, "item during clear")
  // The random victim lies among the ways in use.
  `SAC_TS_ASSERT_NOW(a_mod_in_range, mod_rsp.done, CntW'(mod_rsp.rem) < ways_eff, "victim out of range")
  // The chosen slot lies among the ways in use when the row is written.
  `SAC_TS_ASSERT_NOW(a_slot_in_range, state_q == S_WRITE, CntW'(slot_q) < ways_eff, "slot out of range")
  // A result is loaded only while the output register is free.
  `SAC_TS_ASSERT_NOW(a_no_overwrite, out_load, !out_busy, "result overwritten")
  // Every accepted item is followed by its row evaluation.
  `SAC_TS_ASSERT_NEXT(a_eval_follows, in_acc, state_q == S_EVAL, "no evaluation after accept")

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench of the set-associative cache tag store
// Drives lookups and installs under random idling and configuration phases,
// predicts every result item with a behavioral copy of the tag store, and
// compares each result field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import sac_ts_pkg::*;

  localparam int unsigned Ways    = DefMaxWayCount;
  localparam int unsigned SetBits = DefMaxSetBits;
  localparam int unsigned Entries = Ways << SetBits;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic [31:0] dirty_evictions;
    logic [31:0] write_misses;
    logic [31:0] read_misses;
    logic [31:0] write_accesses;
    logic [31:0] read_accesses;
    logic [31:0] victim_line_addr;
    logic        victim_dirty;
    logic        victim_valid;
    logic        hit;
  } result_t;

  typedef struct {
    logic        kind;
    logic [31:0] addr;
    logic        dirty;
    logic [31:0] stamp;
    logic        check_fixed;
    result_t     fixed;
  } access_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic [InUserW-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDatW-1:0] cfg_data_i = '0;

  // Shadow copy of the tag store.
  bit          shadow_valid [Entries];
  bit          shadow_dirty [Entries];
  logic [31:0] shadow_tag [Entries];
  logic [31:0] shadow_stamp [Entries];
  logic [31:0] shadow_counts [5];
  logic [15:0] shadow_lfsr;
  bit          use_random;
  logic [4:0]  cfg_ways;
  logic [3:0]  cfg_set_bits;

  result_t expected_results[$];
  int      error_count = 0;
  int      idle_cycles = 0;
  bit      long_hold = 1'b0;
  access_t directed_rows[$];

  set_assoc_cache_tag_store_core dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Computes the result of one item and updates the shadow store.
  function automatic result_t predict_access(input logic kind, input logic [31:0] addr,
                                             input logic dirty, input logic [31:0] stamp);
    result_t     r;
    int unsigned nways, bits, base, slot, e;
    logic [31:0] best;
    bit          feedback;
    r = '0;
    nways = (cfg_ways == 0) ? 1 : (cfg_ways > Ways) ? Ways : cfg_ways;
    bits = (cfg_set_bits > SetBits) ? SetBits : cfg_set_bits;
    base = (addr & ((32'd1 << bits) - 1)) * Ways;
    if (kind == ReqLookup) begin
      shadow_counts[dirty ? 1 : 0]++;
      for (int w = 0; w < nways; w++) begin
        e = base + w;
        if (shadow_valid[e] && shadow_tag[e] == addr) begin
          r.hit = 1'b1;
          shadow_stamp[e] = stamp;
          if (dirty) shadow_dirty[e] = 1'b1;
          break;
        end
      end
      if (!r.hit) shadow_counts[dirty ? 3 : 2]++;
    end else begin
      slot = nways;
      for (int w = 0; w < nways; w++) begin
        if (!shadow_valid[base + w]) begin
          slot = w;
          break;
        end
      end
      if (slot == nways) begin
        if (use_random) begin
          feedback = shadow_lfsr[0] ^ shadow_lfsr[2] ^ shadow_lfsr[3] ^ shadow_lfsr[5];
          shadow_lfsr = {feedback, shadow_lfsr[15:1]};
          slot = shadow_lfsr % nways;
        end else begin
          best = shadow_stamp[base];
          slot = 0;
          for (int w = 1; w < nways; w++) begin
            if (shadow_stamp[base + w] < best) begin
              best = shadow_stamp[base + w];
              slot = w;
            end
          end
        end
        e = base + slot;
        r.victim_valid = 1'b1;
        r.victim_dirty = shadow_dirty[e];
        r.victim_line_addr = shadow_tag[e];
        if (shadow_dirty[e]) shadow_counts[4]++;
      end
      e = base + slot;
      shadow_valid[e] = 1'b1;
      shadow_dirty[e] = dirty;
      shadow_tag[e] = addr;
      shadow_stamp[e] = stamp;
    end
    r.read_accesses = shadow_counts[0];
    r.write_accesses = shadow_counts[1];
    r.read_misses = shadow_counts[2];
    r.write_misses = shadow_counts[3];
    r.dirty_evictions = shadow_counts[4];
    return r;
  endfunction

  // Short gaps mostly, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Writes one register, then waits with the channel idle.
  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [4:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgRandomRepl: use_random = value[0];
      CfgWaysInUse:  cfg_ways = value;
      default:       cfg_set_bits = value[3:0];
    endcase
    @(posedge clk_i);
  endtask

  // Waits for all results, then waits on with no item offered.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Offers one item, holding it until accepted; valid stays up between
  // items that follow without a gap.
  task automatic send_access(input access_t a);
    result_t r;
    int      gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {a.stamp, a.addr};
    s_axis_tuser <= {a.dirty, a.kind};
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_access(a.kind, a.addr, a.dirty, a.stamp);
    if (a.check_fixed && r != a.fixed) begin
      report_mismatch("directed row", r[31:0], a.fixed[31:0]);
    end
    expected_results.push_back(r);
  endtask

  function automatic access_t make_access(input logic kind, input logic [31:0] addr,
                                          input logic dirty, input logic [31:0] stamp);
    access_t a;
    a.kind = kind;
    a.addr = addr;
    a.dirty = dirty;
    a.stamp = stamp;
    a.check_fixed = 1'b0;
    a.fixed = '0;
    return a;
  endfunction

  // Random items over a narrow address pool so that sets fill and evict.
  task automatic run_random(input int count, input int pool);
    access_t a;
    logic [31:0] addr;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) addr = $urandom();
      else addr = {$urandom_range(0, 3) == 0 ? $urandom() : 32'd0} ^
                  $urandom_range(0, pool);
      a = make_access($urandom_range(0, 99) < 45, addr, 1'($urandom_range(0, 1)),
                      $urandom());
      send_access(a);
    end
  endtask

  // Receiver: random stalls, one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  // Checks each result against the oldest expectation.
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[194:0];
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", got[31:0], 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
        if (got.victim_valid !== want.victim_valid)
          report_mismatch("victim_valid", got.victim_valid, want.victim_valid);
        if (got.victim_dirty !== want.victim_dirty)
          report_mismatch("victim_dirty", got.victim_dirty, want.victim_dirty);
        if (got.victim_line_addr !== want.victim_line_addr)
          report_mismatch("victim_line_addr", got.victim_line_addr, want.victim_line_addr);
        if (got.read_accesses !== want.read_accesses)
          report_mismatch("read_accesses", got.read_accesses, want.read_accesses);
        if (got.write_accesses !== want.write_accesses)
          report_mismatch("write_accesses", got.write_accesses, want.write_accesses);
        if (got.read_misses !== want.read_misses)
          report_mismatch("read_misses", got.read_misses, want.read_misses);
        if (got.write_misses !== want.write_misses)
          report_mismatch("write_misses", got.write_misses, want.write_misses);
        if (got.dirty_evictions !== want.dirty_evictions)
          report_mismatch("dirty_evictions", got.dirty_evictions, want.dirty_evictions);
      end
    end
  end

  // Watchdog on cycles without any handshake; covers the clearing pass.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    access_t a;
    shadow_valid = '{default: 1'b0};
    shadow_dirty = '{default: 1'b0};
    shadow_counts = '{default: 32'd0};
    shadow_lfsr = LfsrSeed;
    use_random = 1'b0;
    cfg_ways = 5'd16;
    cfg_set_bits = 4'd10;

    // Directed rows: extremes, both kinds, hits, miss counters.
    a = make_access(ReqLookup, 32'h0, 1'b0, 32'h0);
    a.check_fixed = 1'b1;
    a.fixed = '0;
    a.fixed.read_accesses = 1;
    a.fixed.read_misses = 1;
    directed_rows.push_back(a);
    a = make_access(ReqLookup, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    a.check_fixed = 1'b1;
    a.fixed = '0;
    a.fixed.read_accesses = 1;
    a.fixed.read_misses = 1;
    a.fixed.write_accesses = 1;
    a.fixed.write_misses = 1;
    directed_rows.push_back(a);
    directed_rows.push_back(make_access(ReqInstall, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    directed_rows.push_back(make_access(ReqLookup, 32'hFFFF_FFFF, 1'b0, 32'h0));
    directed_rows.push_back(make_access(ReqLookup, 32'hFFFF_FFFF, 1'b1, 32'h5));
    directed_rows.push_back(make_access(ReqInstall, 32'h0, 1'b0, 32'h0));
    directed_rows.push_back(make_access(ReqLookup, 32'h0, 1'b1, 32'h8000_0000));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) send_access(directed_rows[i]);
    wait_drained();

    // One way, one set: every install evicts.
    write_register(CfgWaysInUse, 5'd1);
    write_register(CfgSetBits, 5'd0);
    for (int i = 0; i < 6; i++)
      send_access(make_access(i % 3 == 0 ? ReqLookup : ReqInstall, 32'h1234_5678 + i[1:0],
                              i[0], i));
    wait_drained();

    // Out-of-range settings: zero ways, oversized ways and set bits.
    write_register(CfgWaysInUse, 5'd0);
    write_register(CfgSetBits, 5'd15);
    run_random(20, 4);
    wait_drained();
    write_register(CfgWaysInUse, 5'd31);
    write_register(CfgRandomRepl, 5'd1);
    run_random(40, 3000);
    wait_drained();

    // Random replacement with a pressure phase: receiver holds off.
    write_register(CfgWaysInUse, 5'd3);
    write_register(CfgSetBits, 5'd1);
    long_hold = 1'b1;
    run_random(140, 15);
    wait_drained();

    // Two least recently used sizes, then random; aliasing over resident lines.
    write_register(CfgRandomRepl, 5'd0);
    write_register(CfgWaysInUse, 5'd4);
    write_register(CfgSetBits, 5'd2);
    run_random(140, 40);
    wait_drained();
    write_register(CfgWaysInUse, 5'd16);
    write_register(CfgSetBits, 5'd0);
    run_random(90, 40);
    wait_drained();
    write_register(CfgRandomRepl, 5'd1);
    write_register(CfgWaysInUse, 5'd7);
    write_register(CfgSetBits, 5'd10);
    run_random(110, 12);
    wait_drained();

    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
